### sv/u8dec_pkg.sv
// Package: shared widths, constants and state/result types for the UTF-8 decoder.
`default_nettype none
package u8dec_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int COUNT_W = 12;
  localparam int BYTES_W = 14;

  // Highest character limit the counters support
  localparam logic [COUNT_W-1:0] CHAR_LIMIT = 12'd4095;
  localparam logic [BYTES_W-1:0] BYTES_MAX  = 14'h3FFF;

  // Lead byte class masks and patterns
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;

  // Continuation bytes still expected after each lead class
  localparam logic [1:0] CONT_NONE = 2'd0;
  localparam logic [1:0] CONT_ONE  = 2'd1;
  localparam logic [1:0] CONT_TWO  = 2'd2;
  localparam logic [1:0] CONT_THREE = 2'd3;

  typedef struct packed {
    logic               finished;
    logic [1:0]         bytes_left;
    logic [COUNT_W-1:0] char_count;
    logic [BYTES_W-1:0] byte_count;
    logic [CP_W-1:0]    accumulator;
  } u8dec_state_t;

  typedef struct packed {
    logic               valid;
    logic [CP_W-1:0]    code_point;
    logic               is_end;
    logic [BYTES_W-1:0] bytes_used;
  } u8dec_result_t;

endpackage
`default_nettype wire

### sv/u8dec_if.sv
// Interfaces: byte request channel and code point result channel.
`default_nettype none
interface u8dec_in_if import u8dec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              starts_string;

  modport source (output valid, output data_byte, output starts_string, input ready);
  modport sink   (input valid, input data_byte, input starts_string, output ready);
endinterface

interface u8dec_out_if import u8dec_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CP_W-1:0]    code_point;
  logic               is_end;
  logic [BYTES_W-1:0] bytes_used;

  modport source (output valid, output code_point, output is_end, output bytes_used,
                  input ready);
  modport sink   (input valid, input code_point, input is_end, input bytes_used,
                  output ready);
endinterface
`default_nettype wire

### sv/u8dec_step.sv
// Decode step: next decoder state and optional result for one input byte.
`default_nettype none
module u8dec_step import u8dec_pkg::*; (
  input  u8dec_state_t       cur,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               starts_string,
  input  logic [COUNT_W-1:0] limit,
  output u8dec_state_t       nxt,
  output u8dec_result_t      res
);

  u8dec_state_t       st;
  logic [BYTES_W-1:0] bytes_inc;
  logic [COUNT_W-1:0] cc_inc;
  logic               emit;
  logic [CP_W-1:0]    emit_cp;
  logic               hit_limit;

  always_comb begin
    // Start flag drops any partial character and clears the counters
    st = cur;
    if (starts_string) begin
      st = '0;
    end

    bytes_inc = (st.byte_count == BYTES_MAX) ? st.byte_count : st.byte_count + 1'b1;
    cc_inc    = st.char_count + 1'b1;
    hit_limit = (cc_inc >= limit);

    nxt     = st;
    res     = '0;
    emit    = 1'b0;
    emit_cp = '0;

    if (st.finished) begin
      // dropped until the next start flag
      emit = 1'b0;
    end else if (st.bytes_left != CONT_NONE) begin
      // continuation: take the low six bits whatever the byte holds
      nxt.byte_count  = bytes_inc;
      nxt.accumulator = {st.accumulator[CP_W-7:0], data_byte[5:0]};
      nxt.bytes_left  = st.bytes_left - 1'b1;
      if (st.bytes_left == CONT_ONE) begin
        emit    = 1'b1;
        emit_cp = {st.accumulator[CP_W-7:0], data_byte[5:0]};
      end
    end else if (data_byte == '0) begin
      // NUL lead byte ends the string
      nxt.finished   = 1'b1;
      res.valid      = 1'b1;
      res.is_end     = 1'b1;
      res.bytes_used = st.byte_count;
    end else begin
      nxt.byte_count = bytes_inc;
      if (!data_byte[7]) begin
        emit    = 1'b1;
        emit_cp = {{(CP_W-BYTE_W){1'b0}}, data_byte};
      end else if ((data_byte & LEAD4_MASK) == LEAD4_PAT) begin
        nxt.accumulator = {{(CP_W-3){1'b0}}, data_byte[2:0]};
        nxt.bytes_left  = CONT_THREE;
      end else if ((data_byte & LEAD3_MASK) == LEAD3_PAT) begin
        nxt.accumulator = {{(CP_W-4){1'b0}}, data_byte[3:0]};
        nxt.bytes_left  = CONT_TWO;
      end else if ((data_byte & LEAD2_MASK) == LEAD2_PAT) begin
        nxt.accumulator = {{(CP_W-5){1'b0}}, data_byte[4:0]};
        nxt.bytes_left  = CONT_ONE;
      end else begin
        // stray high byte decodes as code point zero
        emit    = 1'b1;
        emit_cp = '0;
      end
    end

    // Character completed: count it and check the limit
    if (emit) begin
      nxt.char_count = cc_inc;
      res.valid      = 1'b1;
      res.code_point = emit_cp;
      if (hit_limit) begin
        nxt.finished   = 1'b1;
        res.is_end     = 1'b1;
        res.bytes_used = nxt.byte_count;
      end
    end
  end

endmodule
`default_nettype wire

### sv/utf8_to_utf32_decoder.sv
// Top level: streaming UTF-8 to UTF-32 code point decoder.
//
//   channel   dir  fields                                  notes
//   in_chan   in   data_byte[7:0], starts_string           valid/ready
//   out_chan  out  code_point[20:0], is_end, bytes_used    valid/ready
//   cfg_*     in   cfg_wdata[11:0] = max_chars             write enable only
//
// One byte per cycle sustained while the result channel is not stalled: a byte is
// captured in the input register and decoded into the result register.
// The throughput is set by the combinational decode step between those registers.
// Reset (rst_n, synchronous) leaves the decoder finished, waiting for a start flag.
// A stalled result holds the input register, even for a byte that gives no result.
`default_nettype none
module utf8_to_utf32_decoder import u8dec_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  u8dec_in_if.sink           in_chan,
  u8dec_out_if.source        out_chan,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  logic [COUNT_W-1:0] limit_r;
  logic               s1_valid_r;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic               s1_start_r;
  u8dec_state_t       st_r;
  u8dec_state_t       st_nxt;
  u8dec_result_t      res;
  logic               out_valid_r;
  logic [CP_W-1:0]    out_cp_r;
  logic               out_end_r;
  logic [BYTES_W-1:0] out_bytes_r;
  logic               out_free;
  logic               adv;
  logic               in_acc;

  assign out_free = !out_valid_r || out_chan.ready;
  assign adv      = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_acc   = in_chan.valid && in_chan.ready;

  // Effective limit: zero acts as one, capped at CHAR_LIMIT
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CHAR_LIMIT;
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        limit_r <= {{(COUNT_W-1){1'b0}}, 1'b1};
      end else if (cfg_wdata > CHAR_LIMIT) begin
        limit_r <= CHAR_LIMIT;
      end else begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r  <= in_chan.data_byte;
      s1_start_r <= in_chan.starts_string;
    end
  end

  u8dec_step u_step (
    .cur           (st_r),
    .data_byte     (s1_byte_r),
    .starts_string (s1_start_r),
    .limit         (limit_r),
    .nxt           (st_nxt),
    .res           (res)
  );

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{finished: 1'b1, bytes_left: CONT_NONE, char_count: '0,
                byte_count: '0, accumulator: '0};
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_cp_r    <= res.code_point;
      out_end_r   <= res.is_end;
      out_bytes_r <= res.bytes_used;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.code_point = out_cp_r;
  assign out_chan.is_end     = out_end_r;
  assign out_chan.bytes_used = out_bytes_r;

  // A partial character never coexists with a finished string
  a_partial_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bytes_left != CONT_NONE |-> !st_r.finished)
    else $error("partial character held while finished");

  // An end result leaves the decoder finished
  a_end_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.valid && res.is_end |=> st_r.finished)
    else $error("end result did not finish the string");

  // Byte count only reported with the end mark
  a_bytes_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_end_r |-> out_bytes_r == '0)
    else $error("bytes_used set on a non-end result");

  // Bytes after the end and before a start flag give no result
  a_drop_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    adv && st_r.finished && !s1_start_r |-> !res.valid)
    else $error("result produced after end of string");

endmodule
`default_nettype wire
